### design/srfc_pkg.sv
// Package for the solenoid and rumble feedback controller.
// Shared types and constants; no dependencies.
package srfc_pkg;

  typedef enum logic [1:0] {
    ACT_ON_SCREEN  = 2'd0,
    ACT_OFF_SCREEN = 2'd1,
    ACT_RELEASED   = 2'd2,
    ACT_SHUTDOWN   = 2'd3
  } action_t;

  localparam logic [1:0] HEAT_SAFE    = 2'd0;
  localparam logic [1:0] HEAT_WARNING = 2'd1;
  localparam logic [1:0] HEAT_FATAL   = 2'd2;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_FAST     = 3'd1;
  localparam logic [2:0] REG_NORMAL   = 3'd2;
  localparam logic [2:0] REG_HOLD     = 3'd3;
  localparam logic [2:0] REG_RUMBLE   = 3'd4;
  localparam logic [2:0] REG_STRENGTH = 3'd5;
  localparam logic [2:0] REG_TNORM    = 3'd6;
  localparam logic [2:0] REG_TWARN    = 3'd7;

  localparam int CFG_DATA_W = 16;

  // One queued event: the input fields plus the converted temperature.
  typedef struct packed {
    action_t      action;
    logic [31:0]  now_ms;
    logic         trigger_held;
    logic signed [9:0] temp_c;
  } event_t;

  typedef struct packed {
    logic        solenoid_on;
    logic [7:0]  rumble_level;
    logic [1:0]  heat_status;
  } result_t;

endpackage

### design/srfc_if.sv
// Valid/ready channel interface with a source and a sink modport.
// Payload type is a parameter; no package dependencies.
interface srfc_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/srfc_front.sv
// Front end: accepts events, converts the temperature sample, queues them.
// Depends on srfc_pkg. Two-entry queue toward the back end.
module srfc_front import srfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_now_ms,
  input  logic        in_trigger_held,
  input  logic [11:0] in_temp_sample,
  output logic        q_valid,
  input  logic        q_ready,
  output event_t      q_data
);
  event_t     mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;
  logic [20:0] prod;
  event_t     ev;

  always_comb begin
    // floor(adc*330/4096) - 50
    prod = {9'd0, in_temp_sample} * 21'd330;
    ev.action = action_t'(in_action);
    ev.now_ms = in_now_ms;
    ev.trigger_held = in_trigger_held;
    ev.temp_c = $signed({1'b0, prod[20:12]}) - 10'sd50;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= ev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### design/srfc_back.sv
// Back end: carries out one event per cycle, when the result register can
// take it, against the controller state. Depends on srfc_pkg.
module srfc_back import srfc_pkg::*; #(
  parameter int BurstShots = 3,
  parameter int AutofireWaitFactor = 3,
  parameter int WarningIntervalMs = 150
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  event_t      q_data,
  input  logic [5:0]  mode_bits,
  input  logic [15:0] fast_interval_ms,
  input  logic [15:0] normal_interval_ms,
  input  logic [15:0] hold_length_ms,
  input  logic [15:0] rumble_interval_ms,
  input  logic [7:0]  rumble_strength,
  input  logic signed [9:0] temp_normal_c,
  input  logic signed [9:0] temp_warning_c,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_data
);
  localparam int BW = $clog2(BurstShots + 2);

  logic        sol_r, sol_nxt, fsp_r, fsp_nxt, ra_r, ra_nxt, rd_r, rd_nxt;
  logic        br_r, br_nxt;
  logic [7:0]  rdrv_r, rdrv_nxt;
  logic [BW-1:0] bs_r, bs_nxt, bss_r, bss_nxt;
  logic [31:0] ss_r, ss_nxt, rs_r, rs_nxt, ts_r, ts_nxt;
  logic signed [9:0] th_r [4];
  logic signed [9:0] th_nxt [4];
  logic [1:0]  slot_r, slot_nxt, heat_r, heat_nxt;
  logic        ov_r;
  result_t     od_r;
  logic        go;

  assign q_ready = !ov_r || out_ready;
  assign go = q_valid && q_ready;
  assign out_valid = ov_r;
  assign out_data = od_r;

  always_comb begin
    logic [31:0] now;
    logic held, burst, autof;
    logic [31:0] iv;
    logic signed [11:0] avg_sum;
    logic signed [9:0] avg;
    logic do_drive, do_rumble, do_burst;
    logic [31:0] len;
    sol_nxt = sol_r; fsp_nxt = fsp_r; ra_nxt = ra_r; rd_nxt = rd_r;
    br_nxt = br_r; rdrv_nxt = rdrv_r; bs_nxt = bs_r; bss_nxt = bss_r;
    ss_nxt = ss_r; rs_nxt = rs_r; ts_nxt = ts_r; slot_nxt = slot_r;
    heat_nxt = heat_r;
    for (int i = 0; i < 4; i++) th_nxt[i] = th_r[i];
    now = q_data.now_ms;
    held = q_data.trigger_held;
    burst = mode_bits[4];
    autof = mode_bits[1];
    iv = 32'd0;
    avg_sum = 12'sd0;
    avg = 10'sd0;
    do_drive = 1'b0;
    do_rumble = 1'b0;
    do_burst = 1'b0;
    len = 32'd0;

    unique case (q_data.action)
      ACT_ON_SCREEN: begin
        if (mode_bits[0]) begin
          if (!held) begin
            if (burst && !br_r) begin
              ss_nxt = now; sol_nxt = 1'b1; fsp_nxt = 1'b0;
              br_nxt = 1'b1; bs_nxt = BW'(1); bss_nxt = BW'(1);
            end else if (!burst) begin
              ss_nxt = now; sol_nxt = 1'b1;
              fsp_nxt = !autof;
            end
          end else if (br_r) begin
            do_burst = 1'b1;
          end else if (autof && !burst) begin
            do_drive = 1'b1;
            iv = sol_r ? {16'd0, fast_interval_ms}
                       : 32'(fast_interval_ms) * 32'(AutofireWaitFactor);
          end else if (fsp_r) begin
            if (sol_r) begin
              if (now - ss_r >= {16'd0, normal_interval_ms}) sol_nxt = 1'b0;
            end else if (now - ss_r >= {16'd0, hold_length_ms}) begin
              fsp_nxt = 1'b0;
              do_drive = 1'b1;
              iv = {16'd0, normal_interval_ms};
            end
          end else if (!burst) begin
            do_drive = 1'b1;
            iv = sol_r ? {16'd0, normal_interval_ms} : {15'd0, normal_interval_ms, 1'b0};
          end
        end else if (mode_bits[2] && mode_bits[3] && !rd_r && !held) begin
          do_rumble = 1'b1;
        end
        // Second rumble step uses state as left by the first; handled below.
      end
      ACT_OFF_SCREEN: begin
        if (mode_bits[2]) begin
          if ((!mode_bits[3] && !rd_r && !held) || ra_r) do_rumble = 1'b1;
        end
        if (br_r) do_burst = 1'b1;
        else if (sol_r && !burst && (now - ss_r >= {16'd0, fast_interval_ms})) begin
          ss_nxt = now; sol_nxt = 1'b0;
        end
      end
      ACT_RELEASED: begin
        if (mode_bits[0]) begin
          if (br_r) do_burst = 1'b1;
          else if (!burst) begin
            fsp_nxt = 1'b0;
            if (now - ss_r >= {16'd0, fast_interval_ms}) begin
              ss_nxt = now; sol_nxt = 1'b0;
            end
          end
        end
        if (mode_bits[3] && mode_bits[1]) begin
          if (ra_r || rd_r) begin
            rdrv_nxt = 8'd0; ra_nxt = 1'b0; rd_nxt = 1'b0;
          end
        end else if (ra_r) do_rumble = 1'b1;
        else if (rd_r) rd_nxt = 1'b0;
      end
      ACT_SHUTDOWN: begin
        sol_nxt = 1'b0; rdrv_nxt = 8'd0; fsp_nxt = 1'b0; ra_nxt = 1'b0;
        rd_nxt = 1'b0; br_nxt = 1'b0; bs_nxt = '0;
      end
      default: ;
    endcase

    if (do_burst) begin
      if (32'(bs_r) <= 32'(BurstShots)) begin
        if (!sol_r && bs_r == bss_r) bs_nxt = bs_r + BW'(1);
        if (!sol_r) iv = {15'd0, fast_interval_ms, 1'b0};
        else begin
          bss_nxt = bs_r;
          iv = {16'd0, fast_interval_ms};
        end
        do_drive = 1'b1;
      end else begin
        br_nxt = 1'b0; bs_nxt = '0;
      end
    end

    // Drive: a pending first shot turns the solenoid on, else it toggles.
    if (do_drive) begin
      if (fsp_nxt) begin
        ss_nxt = now; sol_nxt = 1'b1;
      end else begin
        if (mode_bits[5]) begin
          if (now - ts_r > 32'd2) begin
            ts_nxt = now;
            th_nxt[slot_r] = q_data.temp_c;
            if (slot_r != 2'd3) slot_nxt = slot_r + 2'd1;
            else begin
              slot_nxt = 2'd0;
              avg_sum = 12'(th_nxt[0]) + 12'(th_nxt[1]) + 12'(th_nxt[2]) + 12'(th_nxt[3]);
              // Truncate toward zero.
              avg = (avg_sum < 0) ? 10'(-((-avg_sum) >>> 2)) : 10'(avg_sum >>> 2);
              if (heat_r == HEAT_FATAL) begin
                if (12'(avg) < 12'(temp_warning_c) - 12'sd5) heat_nxt = HEAT_WARNING;
              end else if (avg >= temp_warning_c) heat_nxt = HEAT_FATAL;
              else if (heat_r == HEAT_WARNING) begin
                if (12'(avg) < 12'(temp_normal_c) - 12'sd5) heat_nxt = HEAT_SAFE;
              end else if (avg >= temp_normal_c) heat_nxt = HEAT_WARNING;
            end
          end
          if (heat_nxt >= HEAT_FATAL) begin
            sol_nxt = 1'b0;
            iv = 32'hFFFF_FFFF;
          end else if (heat_nxt == HEAT_WARNING && !sol_r) iv = 32'(WarningIntervalMs);
          if (heat_nxt < HEAT_FATAL && now - ss_r >= iv) begin
            ss_nxt = now; sol_nxt = !sol_r;
          end
        end else if (now - ss_r >= iv) begin
          ss_nxt = now; sol_nxt = !sol_r;
        end
      end
    end

    // Rumble: up to two steps on screen (second when active and held).
    for (int k = 0; k < 2; k++) begin
      logic step;
      step = (k == 0) ? do_rumble
           : (q_data.action == ACT_ON_SCREEN && mode_bits[2] && ra_nxt && held);
      if (step) begin
        if (!ra_nxt) begin
          rs_nxt = now; rdrv_nxt = rumble_strength; ra_nxt = 1'b1;
        end else if (!(mode_bits[3] && mode_bits[1])) begin
          len = mode_bits[3] ? {17'd0, rumble_interval_ms[15:1]} : {16'd0, rumble_interval_ms};
          if (now - rs_nxt >= len) begin
            rdrv_nxt = 8'd0; ra_nxt = 1'b0; rd_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sol_r <= 1'b0; fsp_r <= 1'b0; ra_r <= 1'b0; rd_r <= 1'b0; br_r <= 1'b0;
      rdrv_r <= 8'd0; bs_r <= '0; bss_r <= '0; ss_r <= '0; rs_r <= '0; ts_r <= '0;
      slot_r <= 2'd0; heat_r <= HEAT_SAFE; ov_r <= 1'b0;
      for (int i = 0; i < 4; i++) th_r[i] <= 10'sd0;
    end else begin
      if (go) begin
        sol_r <= sol_nxt; fsp_r <= fsp_nxt; ra_r <= ra_nxt; rd_r <= rd_nxt;
        br_r <= br_nxt; rdrv_r <= rdrv_nxt; bs_r <= bs_nxt; bss_r <= bss_nxt;
        ss_r <= ss_nxt; rs_r <= rs_nxt; ts_r <= ts_nxt; slot_r <= slot_nxt;
        heat_r <= heat_nxt;
        for (int i = 0; i < 4; i++) th_r[i] <= th_nxt[i];
      end
      if (go) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      od_r.solenoid_on <= sol_nxt;
      od_r.rumble_level <= rdrv_nxt;
      od_r.heat_status <= heat_nxt;
    end
  end
endmodule

### design/solenoid_rumble_feedback_controller.sv
// Solenoid and rumble feedback controller, top level. Uses srfc_pkg, srfc_if,
// srfc_front and srfc_back.
// Path: each transaction is queued in the front end, then its result is registered.
// Throughput: one transaction per cycle while out_ready is held high.
// Reset: synchronous, active low; returns control and config registers to defaults.
module solenoid_rumble_feedback_controller import srfc_pkg::*; #(
  parameter int BURST_SHOTS = 3,
  parameter int AUTOFIRE_WAIT_FACTOR = 3,
  parameter int WARNING_INTERVAL_MS = 150
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_now_ms,
  input  logic        in_trigger_held,
  input  logic [11:0] in_temp_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_solenoid_on,
  output logic [7:0]  out_rumble_level,
  output logic [1:0]  out_heat_status,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  srfc_if #(.payload_t(event_t))  q_ch ();
  srfc_if #(.payload_t(result_t)) r_ch ();

  logic [5:0]  mode_r;
  logic [15:0] fast_r, normal_r, hold_r, rint_r;
  logic [7:0]  str_r;
  logic signed [9:0] tnorm_r, twarn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 6'd1; fast_r <= 16'd30; normal_r <= 16'd45; hold_r <= 16'd500;
      rint_r <= 16'd150; str_r <= 8'd255; tnorm_r <= 10'sd50; twarn_r <= 10'sd60;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:     mode_r <= cfg_data[5:0];
        REG_FAST:     fast_r <= cfg_data;
        REG_NORMAL:   normal_r <= cfg_data;
        REG_HOLD:     hold_r <= cfg_data;
        REG_RUMBLE:   rint_r <= cfg_data;
        REG_STRENGTH: str_r <= cfg_data[7:0];
        REG_TNORM:    tnorm_r <= cfg_data[9:0];
        REG_TWARN:    twarn_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  srfc_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_action, .in_now_ms, .in_trigger_held,
    .in_temp_sample, .q_valid(q_ch.valid), .q_ready(q_ch.ready), .q_data(q_ch.data)
  );

  srfc_back #(
    .BurstShots(BURST_SHOTS), .AutofireWaitFactor(AUTOFIRE_WAIT_FACTOR),
    .WarningIntervalMs(WARNING_INTERVAL_MS)
  ) u_back (
    .clk, .rst_n, .q_valid(q_ch.valid), .q_ready(q_ch.ready), .q_data(q_ch.data),
    .mode_bits(mode_r), .fast_interval_ms(fast_r), .normal_interval_ms(normal_r),
    .hold_length_ms(hold_r), .rumble_interval_ms(rint_r), .rumble_strength(str_r),
    .temp_normal_c(tnorm_r), .temp_warning_c(twarn_r),
    .out_valid(r_ch.valid), .out_ready(r_ch.ready), .out_data(r_ch.data)
  );

  assign r_ch.ready = out_ready;
  assign out_valid = r_ch.valid;
  assign out_solenoid_on = r_ch.data.solenoid_on;
  assign out_rumble_level = r_ch.data.rumble_level;
  assign out_heat_status = r_ch.data.heat_status;

  a_heat_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heat_status != 2'd3)) else $error("bad heat code");
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rumble_level))
    else $error("result dropped while stalled");
  a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_ch.valid) else $error("queue full but empty");
endmodule

### sim/tb_solenoid_rumble_feedback_controller.sv
// Testbench for the solenoid and rumble feedback controller.
// Depends on srfc_pkg, srfc_if and the controller RTL; a scoreboard class predicts each result.
module tb_solenoid_rumble_feedback_controller import srfc_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    action_t     action;
    logic [31:0] now_ms;
    logic        trigger_held;
    logic [11:0] temp_sample;
  } poll_t;

  localparam int NUM_PHASES = 12;
  localparam int PHASE_ITEMS = 100;
  localparam int STALL_LIMIT = 4000;
  localparam int BURST_MAX = 3;
  localparam int AUTO_FACTOR = 3;
  localparam int WARN_HOLD_MS = 150;

  // Predicts the controller's outputs and holds the results still owed by it.
  class feedback_scoreboard;
    bit [5:0] mode;
    bit [15:0] fast_ms, normal_ms, hold_ms, rumble_ms;
    bit [7:0] strength;
    bit signed [9:0] tnorm, twarn;
    bit sol, pend, ract, rdone, brun;
    bit [7:0] rdrive;
    int bshots, bseen, slot;
    bit [31:0] sstamp, rstamp, tstamp, now;
    int hist[4];
    bit [1:0] heat;
    bit [11:0] sample;
    result_t owed_q[$];
    int errors;
    int checked;

    function new();
      mode = 6'd1; fast_ms = 30; normal_ms = 45; hold_ms = 500; rumble_ms = 150;
      strength = 255; tnorm = 50; twarn = 60;
      sol = 0; pend = 0; ract = 0; rdone = 0; brun = 0; rdrive = 0;
      bshots = 0; bseen = 0; slot = 0; sstamp = 0; rstamp = 0; tstamp = 0; now = 0;
      foreach (hist[i]) hist[i] = 0;
      heat = HEAT_SAFE; errors = 0; checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_MODE:     mode = data[5:0];
        REG_FAST:     fast_ms = data;
        REG_NORMAL:   normal_ms = data;
        REG_HOLD:     hold_ms = data;
        REG_RUMBLE:   rumble_ms = data;
        REG_STRENGTH: strength = data[7:0];
        REG_TNORM:    tnorm = data[9:0];
        REG_TWARN:    twarn = data[9:0];
        default: ;
      endcase
    endfunction

    function bit waited(bit [31:0] stamp, int unsigned iv);
      bit [31:0] d;
      d = now - stamp;
      return d >= iv;
    endfunction

    function void thermal();
      bit [31:0] d;
      int avg;
      int w;
      int n;
      d = now - tstamp;
      if (d <= 2) return;
      tstamp = now;
      hist[slot] = (int'(sample) * 330) / 4096 - 50;
      if (slot < 3) begin
        slot++;
        return;
      end
      slot = 0;
      avg = (hist[0] + hist[1] + hist[2] + hist[3]) / 4;
      w = twarn;
      n = tnorm;
      if (heat == HEAT_FATAL) begin
        if (avg < w - 5) heat = HEAT_WARNING;
      end else if (avg >= w) begin
        heat = HEAT_FATAL;
      end else if (heat == HEAT_WARNING) begin
        if (avg < n - 5) heat = HEAT_SAFE;
      end else if (avg >= n) begin
        heat = HEAT_WARNING;
      end
    endfunction

    function void toggle_if(int unsigned iv);
      if (waited(sstamp, iv)) begin
        sstamp = now;
        sol = ~sol;
      end
    endfunction

    function void fire(int unsigned iv);
      if (pend) begin
        sstamp = now;
        sol = 1;
      end else if (mode[5]) begin
        thermal();
        if (heat >= HEAT_FATAL) sol = 0;
        else if (heat == HEAT_WARNING && !sol) toggle_if(WARN_HOLD_MS);
        else toggle_if(iv);
      end else begin
        toggle_if(iv);
      end
    endfunction

    function void rumble_step();
      int unsigned len;
      if (!ract) begin
        rstamp = now;
        rdrive = strength;
        ract = 1;
        return;
      end
      if (mode[3]) begin
        if (mode[1]) return;
        len = rumble_ms / 2;
      end else begin
        len = rumble_ms;
      end
      if (waited(rstamp, len)) begin
        rdrive = 0;
        ract = 0;
        rdone = 1;
      end
    endfunction

    function void burst_step();
      if (bshots <= BURST_MAX) begin
        if (!sol && bshots == bseen) bshots++;
        if (!sol) begin
          fire(int'(fast_ms) * 2);
        end else begin
          bseen = bshots;
          fire(fast_ms);
        end
      end else begin
        brun = 0;
        bshots = 0;
      end
    endfunction

    function void on_screen(bit held);
      if (mode[0]) begin
        if (!held) begin
          if (mode[4] && !brun) begin
            pend = 1;
            fire(0);
            pend = 0;
            brun = 1;
            bshots = 1;
            bseen = 1;
          end else if (!mode[4]) begin
            pend = 1;
            fire(0);
            if (mode[1]) pend = 0;
          end
        end else if (brun) begin
          burst_step();
        end else if (mode[1] && !mode[4]) begin
          fire(sol ? int'(fast_ms) : int'(fast_ms) * AUTO_FACTOR);
        end else if (pend) begin
          if (sol) begin
            if (waited(sstamp, normal_ms)) sol = 0;
          end else if (waited(sstamp, hold_ms)) begin
            pend = 0;
            fire(normal_ms);
          end
        end else if (!mode[4]) begin
          fire(sol ? int'(normal_ms) : int'(normal_ms) * 2);
        end
      end else if (mode[2] && mode[3] && !rdone && !held) begin
        rumble_step();
      end
      if (mode[2] && ract && held) rumble_step();
    endfunction

    function void off_screen(bit held);
      if (mode[2]) begin
        if (!mode[3] && !rdone && !held) rumble_step();
        else if (ract) rumble_step();
      end
      if (brun) begin
        burst_step();
      end else if (sol && !mode[4]) begin
        if (waited(sstamp, fast_ms)) begin
          sstamp = now;
          sol = 0;
        end
      end
    endfunction

    function void released();
      if (mode[0]) begin
        if (brun) begin
          burst_step();
        end else if (!mode[4]) begin
          pend = 0;
          if (waited(sstamp, fast_ms)) begin
            sstamp = now;
            sol = 0;
          end
        end
      end
      if (mode[3] && mode[1]) begin
        if (ract || rdone) begin
          rdrive = 0;
          ract = 0;
          rdone = 0;
        end
      end else if (ract) begin
        rumble_step();
      end else if (rdone) begin
        rdone = 0;
      end
    endfunction

    function void note_poll(poll_t p);
      result_t r;
      now = p.now_ms;
      sample = p.temp_sample;
      case (p.action)
        ACT_ON_SCREEN:  on_screen(p.trigger_held);
        ACT_OFF_SCREEN: off_screen(p.trigger_held);
        ACT_RELEASED:   released();
        default: begin
          sol = 0; rdrive = 0; pend = 0; ract = 0; rdone = 0; brun = 0; bshots = 0;
        end
      endcase
      r.solenoid_on = sol;
      r.rumble_level = rdrive;
      r.heat_status = heat;
      owed_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      checked++;
      if (owed_q.size() == 0) begin
        $error("result with no transaction outstanding: %p", got);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.solenoid_on !== want.solenoid_on) begin
        $error("solenoid_on: expected %0d, got %0d", want.solenoid_on, got.solenoid_on);
        errors++;
      end
      if (got.rumble_level !== want.rumble_level) begin
        $error("rumble_level: expected %0d, got %0d", want.rumble_level, got.rumble_level);
        errors++;
      end
      if (got.heat_status !== want.heat_status) begin
        $error("heat_status: expected %0d, got %0d", want.heat_status, got.heat_status);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  srfc_if #(.payload_t(poll_t)) in_ch ();
  srfc_if #(.payload_t(result_t)) out_ch ();

  solenoid_rumble_feedback_controller DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .in_action(in_ch.data.action),
    .in_now_ms(in_ch.data.now_ms),
    .in_trigger_held(in_ch.data.trigger_held),
    .in_temp_sample(in_ch.data.temp_sample),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_solenoid_on(out_ch.data.solenoid_on),
    .out_rumble_level(out_ch.data.rumble_level),
    .out_heat_status(out_ch.data.heat_status),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  feedback_scoreboard board = new();
  int send_idle_pct;
  int recv_idle_pct;
  int stall_count;
  int polls_sent;
  bit [31:0] clock_ms;
  int temp_base;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Result side: ready is chosen at the falling edge, transactions checked at the rising edge.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("tb_solenoid_rumble_feedback_controller: done, errors");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_poll(input poll_t p);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data = p;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    board.note_poll(p);
    polls_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (board.owed_q.size() != 0) @(posedge clk);
    // The result register may still be busy right after the last transaction.
    repeat (4) @(posedge clk);
  endtask

  task automatic poll(input action_t a, input bit held);
    poll_t p;
    int r;
    r = $urandom_range(99);
    if (r < 2) clock_ms = $urandom;
    else if (r < 8) clock_ms += $urandom_range(2000);
    else clock_ms += $urandom_range(40);
    if ($urandom_range(9) == 0) temp_base = $urandom_range(4095);
    p.action = a;
    p.now_ms = clock_ms;
    p.trigger_held = held;
    r = temp_base + $urandom_range(400) - 200;
    p.temp_sample = (r < 0) ? 12'd0 : (r > 4095) ? 12'd4095 : r[11:0];
    send_poll(p);
  endtask

  task automatic configure(input int phase);
    logic [15:0] v;
    int t;
    for (int i = 0; i < 8; i++) begin
      if (phase == 1) begin
        v = (i == REG_TNORM || i == REG_TWARN) ? 16'hFFCE : 16'd0;
      end else if (phase == 2) begin
        v = (i == REG_TNORM || i == REG_TWARN) ? 16'd280 : 16'hFFFF;
      end else if (i == REG_MODE) begin
        v = 16'($urandom_range(63));
      end else if (i == REG_HOLD) begin
        v = 16'($urandom_range(600));
      end else if (i == REG_STRENGTH) begin
        v = 16'($urandom_range(255));
      end else if (i == REG_TNORM || i == REG_TWARN) begin
        t = ($urandom_range(4) == 0) ? $urandom_range(1023) : $urandom_range(330) - 50;
        v = 16'(t);
      end else begin
        v = 16'($urandom_range(150));
      end
      write_reg(i[2:0], v);
    end
  endtask

  // A trigger pull: first poll not held, a run of held polls, a release, sometimes a shutdown.
  task automatic trigger_pull();
    int n;
    n = $urandom_range(1, 25);
    poll(($urandom_range(3) == 0) ? ACT_OFF_SCREEN : ACT_ON_SCREEN, 1'b0);
    for (int i = 0; i < n; i++) begin
      poll(($urandom_range(5) == 0) ? ACT_OFF_SCREEN : ACT_ON_SCREEN, 1'b1);
    end
    poll(ACT_RELEASED, 1'($urandom_range(1)));
    if ($urandom_range(9) == 0) poll(ACT_SHUTDOWN, 1'($urandom_range(1)));
  endtask

  initial begin
    poll_t p;
    int start;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_MODE;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    stall_count = 0;
    polls_sent = 0;
    clock_ms = 32'hFFFF_FF00;
    temp_base = 2000;
    send_idle_pct = 7;
    recv_idle_pct = 77;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: defaults, then all mode bits on, a warning threshold of -1 and a wrap of time.
    poll(ACT_ON_SCREEN, 1'b0);
    poll(ACT_ON_SCREEN, 1'b1);
    poll(ACT_OFF_SCREEN, 1'b1);
    poll(ACT_RELEASED, 1'b0);
    poll(ACT_SHUTDOWN, 1'b1);
    drain();
    write_reg(REG_MODE, 16'h003F);
    write_reg(REG_TWARN, 16'h03FF);
    for (int i = 0; i < 12; i++) begin
      p.action = (i == 11) ? ACT_SHUTDOWN : (i % 3 == 2) ? ACT_OFF_SCREEN : ACT_ON_SCREEN;
      p.now_ms = (i == 0) ? 32'hFFFF_FFFF : (i == 1) ? 32'd0 : 32'd4 * i;
      p.trigger_held = (i != 0);
      p.temp_sample = (i % 2) ? 12'hFFF : 12'h000;
      send_poll(p);
    end
    for (int i = 0; i < 6; i++) poll(action_t'(i % 4), i[0]);
    drain();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase < 4) begin
        send_idle_pct = 7;
        recv_idle_pct = 77;
      end else if (phase < 8) begin
        send_idle_pct = 77;
        recv_idle_pct = 7;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      configure(phase);
      start = polls_sent;
      while (polls_sent - start < PHASE_ITEMS) begin
        if ($urandom_range(99) < 80) trigger_pull();
        else poll(action_t'($urandom_range(3)), 1'($urandom_range(1)));
      end
      drain();
    end

    $display("covered %0d polls over %0d register settings, %0d results checked",
             polls_sent, NUM_PHASES + 2, board.checked);
    if (board.errors == 0 && board.owed_q.size() == 0) begin
      $display("tb_solenoid_rumble_feedback_controller: done, clean");
    end else begin
      $display("tb_solenoid_rumble_feedback_controller: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
design/srfc_pkg.sv
design/srfc_if.sv
design/srfc_front.sv
design/srfc_back.sv
design/solenoid_rumble_feedback_controller.sv
sim/tb_solenoid_rumble_feedback_controller.sv
